[rtl/e2q_pkg.sv]
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, constants and fixed-point helpers for the Euler-to-quaternion
// pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int ANGLE_BITS        = 16;
    localparam int OUT_FRAC_BITS     = 15;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;

    // Datapath: signed, 30 fractional bits
    localparam int WFRAC  = 30;
    localparam int DW     = 32;
    localparam int SUM_W  = DW + 1;
    localparam int OUT_SH = WFRAC - OUT_FRAC_BITS;

    localparam int LANES      = 3;
    localparam int LANE_ROLL  = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_YAW   = 2;

    typedef logic signed [DW-1:0] fix_t;

    // 1/K, Q2.30
    localparam fix_t CORDIC_GAIN = 32'sd652032874;

    // atan(2^-i), 2^32 = one turn
    localparam fix_t ATAN_TABLE [ATAN_ENTRIES] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
        32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
        32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
        32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
        32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
        32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
    };

    localparam logic signed [2*DW-1:0] MUL_RND = (2*DW)'(1) << (WFRAC - 1);
    localparam logic [SUM_W:0]         OUT_RND = (SUM_W+1)'(1) << (OUT_SH - 1);

    typedef struct packed {
        logic [ANGLE_BITS-1:0] roll_angle;
        logic [ANGLE_BITS-1:0] pitch_angle;
        logic [ANGLE_BITS-1:0] yaw_angle;
    } angle_word_t;

    typedef struct packed {
        logic signed [OUT_FRAC_BITS:0] quat_x;
        logic signed [OUT_FRAC_BITS:0] quat_y;
        logic signed [OUT_FRAC_BITS:0] quat_z;
        logic signed [OUT_FRAC_BITS:0] quat_w;
    } quat_word_t;

    typedef struct packed {
        fix_t s;
        fix_t c;
    } sincos_t;

    // Q.30 product, round half up
    function automatic fix_t fmul(input fix_t a, input fix_t b);
        logic signed [2*DW-1:0] p;
        p = a * b + MUL_RND;
        return p[DW+WFRAC-1:WFRAC];
    endfunction

    // Q.30 sum to Q1.OUT_FRAC_BITS, round half up, saturate
    function automatic logic signed [OUT_FRAC_BITS:0] to_out(
        input logic signed [SUM_W-1:0] v
    );
        logic [SUM_W:0]                              r;
        logic [SUM_W-OUT_SH:0]                       q;
        logic [SUM_W-OUT_SH-OUT_FRAC_BITS:0]         hi_bits;
        r       = {v[SUM_W-1], v} + OUT_RND;
        q       = r[SUM_W:OUT_SH];
        hi_bits = q[SUM_W-OUT_SH:OUT_FRAC_BITS];
        if ((&hi_bits) || !(|hi_bits))
            return q[OUT_FRAC_BITS:0];
        else if (q[SUM_W-OUT_SH])
            return {1'b1, {OUT_FRAC_BITS{1'b0}}};
        else
            return {1'b0, {OUT_FRAC_BITS{1'b1}}};
    endfunction

endpackage

[rtl/e2q_sincos.sv]
// ----------------------------------------------------------------------------
// e2q_sincos
// Three-lane unrolled CORDIC: sine and cosine of the half roll, pitch and yaw
// angles, one register stage per iteration.
// ----------------------------------------------------------------------------
module e2q_sincos #(
    parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  e2q_pkg::angle_word_t angles,
    output logic                 out_valid,
    output e2q_pkg::sincos_t     sc [e2q_pkg::LANES]
);
    import e2q_pkg::*;

    // iterations past the table length do nothing
    localparam int NUM_ITER = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    logic [ANGLE_BITS-1:0] lane_angle [LANES];

    logic [NUM_ITER:0]  vld_reg;
    logic [NUM_ITER:0]  vld_next;
    fix_t               x_reg  [NUM_ITER+1][LANES];
    fix_t               y_reg  [NUM_ITER+1][LANES];
    fix_t               z_reg  [NUM_ITER+1][LANES];
    fix_t               x_next [NUM_ITER+1][LANES];
    fix_t               y_next [NUM_ITER+1][LANES];
    fix_t               z_next [NUM_ITER+1][LANES];
    logic [LANES-1:0]   up_reg  [NUM_ITER+1];
    logic [LANES-1:0]   up_next [NUM_ITER+1];

    logic               fold_vld_reg;
    logic               fold_vld_next;
    sincos_t            fold_reg  [LANES];
    sincos_t            fold_next [LANES];

    assign lane_angle[LANE_ROLL]  = angles.roll_angle;
    assign lane_angle[LANE_PITCH] = angles.pitch_angle;
    assign lane_angle[LANE_YAW]   = angles.yaw_angle;

    assign vld_next      = {vld_reg[NUM_ITER-1:0], in_valid};
    assign fold_vld_next = vld_reg[NUM_ITER];

    always_comb
    begin
        fix_t dx;
        fix_t dy;
        dx = '0;
        dy = '0;
        // Half angle; a top bit set means a quarter turn or more, folded out here
        for (int l = 0; l < LANES; l++)
        begin
            x_next[0][l]  = CORDIC_GAIN;
            y_next[0][l]  = '0;
            z_next[0][l]  = {2'b00, lane_angle[l][ANGLE_BITS-2:0],
                             {(DW-1-ANGLE_BITS){1'b0}}};
            up_next[0][l] = lane_angle[l][ANGLE_BITS-1];
        end
        for (int i = 1; i <= NUM_ITER; i++)
        begin
            up_next[i] = up_reg[i-1];
            for (int l = 0; l < LANES; l++)
            begin
                dx = y_reg[i-1][l] >>> (i - 1);
                dy = x_reg[i-1][l] >>> (i - 1);
                if (!z_reg[i-1][l][DW-1])
                begin
                    x_next[i][l] = x_reg[i-1][l] - dx;
                    y_next[i][l] = y_reg[i-1][l] + dy;
                    z_next[i][l] = z_reg[i-1][l] - ATAN_TABLE[i-1];
                end
                else
                begin
                    x_next[i][l] = x_reg[i-1][l] + dx;
                    y_next[i][l] = y_reg[i-1][l] - dy;
                    z_next[i][l] = z_reg[i-1][l] + ATAN_TABLE[i-1];
                end
            end
        end
    end

    // rotate back by a quarter turn: cos = -sin', sin = cos'
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (up_reg[NUM_ITER][l])
            begin
                fold_next[l].s = x_reg[NUM_ITER][l];
                fold_next[l].c = -y_reg[NUM_ITER][l];
            end
            else
            begin
                fold_next[l].s = y_reg[NUM_ITER][l];
                fold_next[l].c = x_reg[NUM_ITER][l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            fold_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg      <= vld_next;
            fold_vld_reg <= fold_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            up_reg   <= up_next;
            fold_reg <= fold_next;
        end
    end

    assign out_valid = fold_vld_reg;
    assign sc        = fold_reg;

endmodule

[rtl/e2q_combine.sv]
// ----------------------------------------------------------------------------
// e2q_combine
// Quaternion products of the half-angle sines and cosines: two multiply
// stages, then sum, round and saturate into the output register.
// ----------------------------------------------------------------------------
module e2q_combine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  e2q_pkg::sincos_t     sc [e2q_pkg::LANES],
    output logic                 out_valid,
    output e2q_pkg::quat_word_t  quat
);
    import e2q_pkg::*;

    logic [2:0] vld_reg;
    logic [2:0] vld_next;

    // stage A: pairwise roll/pitch products
    fix_t srcp_reg, crsp_reg, crcp_reg, srsp_reg, cy_reg, sy_reg;
    fix_t srcp_next, crsp_next, crcp_next, srsp_next, cy_next, sy_next;

    // stage B: terms of each component
    fix_t x1_reg, x2_reg, y1_reg, y2_reg, z1_reg, z2_reg, w1_reg, w2_reg;
    fix_t x1_next, x2_next, y1_next, y2_next, z1_next, z2_next, w1_next, w2_next;

    quat_word_t quat_reg;
    quat_word_t quat_next;

    logic signed [SUM_W-1:0] qx_sum, qy_sum, qz_sum, qw_sum;

    assign vld_next = {vld_reg[1:0], in_valid};

    always_comb
    begin
        srcp_next = fmul(sc[LANE_ROLL].s, sc[LANE_PITCH].c);
        crsp_next = fmul(sc[LANE_ROLL].c, sc[LANE_PITCH].s);
        crcp_next = fmul(sc[LANE_ROLL].c, sc[LANE_PITCH].c);
        srsp_next = fmul(sc[LANE_ROLL].s, sc[LANE_PITCH].s);
        cy_next   = sc[LANE_YAW].c;
        sy_next   = sc[LANE_YAW].s;
    end

    always_comb
    begin
        x1_next = fmul(srcp_reg, cy_reg);
        x2_next = fmul(crsp_reg, sy_reg);
        y1_next = fmul(crsp_reg, cy_reg);
        y2_next = fmul(srcp_reg, sy_reg);
        z1_next = fmul(crcp_reg, sy_reg);
        z2_next = fmul(srsp_reg, cy_reg);
        w1_next = fmul(crcp_reg, cy_reg);
        w2_next = fmul(srsp_reg, sy_reg);
    end

    always_comb
    begin
        qx_sum           = {x1_reg[DW-1], x1_reg} - {x2_reg[DW-1], x2_reg};
        qy_sum           = {y1_reg[DW-1], y1_reg} + {y2_reg[DW-1], y2_reg};
        qz_sum           = {z1_reg[DW-1], z1_reg} - {z2_reg[DW-1], z2_reg};
        qw_sum           = {w1_reg[DW-1], w1_reg} + {w2_reg[DW-1], w2_reg};
        quat_next.quat_x = to_out(qx_sum);
        quat_next.quat_y = to_out(qy_sum);
        quat_next.quat_z = to_out(qz_sum);
        quat_next.quat_w = to_out(qw_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srcp_reg <= srcp_next;
            crsp_reg <= crsp_next;
            crcp_reg <= crcp_next;
            srsp_reg <= srsp_next;
            cy_reg   <= cy_next;
            sy_reg   <= sy_next;
            x1_reg   <= x1_next;
            x2_reg   <= x2_next;
            y1_reg   <= y1_next;
            y2_reg   <= y2_next;
            z1_reg   <= z1_next;
            z2_reg   <= z2_next;
            w1_reg   <= w1_next;
            w2_reg   <= w2_next;
            quat_reg <= quat_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign quat      = quat_reg;

endmodule

[rtl/euler_to_quaternion_top.sv]
// ----------------------------------------------------------------------------
// euler_to_quaternion_top
// Roll, pitch and yaw binary angles (Z-Y-X) to a unit quaternion, Q1.15.
//
// Input channel angle/angle_valid/angle_stall carries one word of three
// angles, one turn = full word range. Output channel quat/quat_valid/
// quat_stall carries x, y, z, w, each saturated at the largest code for +1.0.
// A word is taken at any edge with valid high and stall low.
//
// Throughput: one word per cycle while no output word waits on quat_stall.
// The pipeline is the unrolled CORDIC, one register per iteration, plus an
// input stage, a quadrant fold, two multiply stages and the sum/round/
// saturate stage that is the output register.
// When quat_stall holds a waiting result, the whole pipeline freezes; one
// more input word lands in a skid register and angle_stall rises the next
// cycle. Reset empties the pipeline and the skid register; the block takes
// words from the first cycle after reset.
// ----------------------------------------------------------------------------
module euler_to_quaternion_top #(
    parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 angle_valid,
    output logic                 angle_stall,
    input  e2q_pkg::angle_word_t angle,
    output logic                 quat_valid,
    input  logic                 quat_stall,
    output e2q_pkg::quat_word_t  quat
);
    import e2q_pkg::*;

    logic        en;
    logic        skid_vld_reg;
    logic        skid_vld_next;
    angle_word_t skid_word_reg;
    angle_word_t skid_word_next;
    logic        pipe_valid;
    angle_word_t pipe_word;

    logic        sc_valid;
    sincos_t     sc [LANES];

    assign en          = !(quat_valid && quat_stall);
    assign angle_stall = skid_vld_reg;

    assign pipe_valid     = skid_vld_reg || angle_valid;
    assign pipe_word      = skid_vld_reg ? skid_word_reg : angle;
    assign skid_vld_next  = !en && pipe_valid;
    assign skid_word_next = skid_vld_reg ? skid_word_reg : angle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_vld_reg <= 1'b0;
        else
            skid_vld_reg <= skid_vld_next;
    end

    always_ff @(posedge clk)
    begin
        skid_word_reg <= skid_word_next;
    end

    e2q_sincos #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pipe_valid),
        .angles    (pipe_word),
        .out_valid (sc_valid),
        .sc        (sc)
    );

    e2q_combine u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sc_valid),
        .sc        (sc),
        .out_valid (quat_valid),
        .quat      (quat)
    );

endmodule

[rtl/e2q_checker.sv]
// ----------------------------------------------------------------------------
// e2q_checker
// Port-level checks on the Euler-to-quaternion block, bound to the top level.
// ----------------------------------------------------------------------------
module e2q_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                angle_valid,
    input logic                angle_stall,
    input logic                quat_valid,
    input logic                quat_stall,
    input e2q_pkg::quat_word_t quat
);
    import e2q_pkg::*;

    // a waiting result stays put
    a_quat_hold: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat_stall |=> quat_valid && $stable(quat))
        else $error("stalled quat word changed or dropped");

    // input stall only follows an output stall
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        angle_stall |-> $past(quat_valid && quat_stall))
        else $error("angle_stall without a stalled output");

    // output moving frees the input on the next cycle
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        !(quat_valid && quat_stall) |=> !angle_stall)
        else $error("angle_stall held while output was moving");

    // skid fills only from an offered word
    a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(angle_stall) |-> $past(angle_valid))
        else $error("angle_stall rose with no word offered");

endmodule

bind euler_to_quaternion_top e2q_checker u_e2q_checker (.*);

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for euler_to_quaternion_top. A short table of probe
// angles (zero, half turns, quadrant edges, bit patterns) runs first. Random
// angle words follow, biased toward the quadrant fold and the ends of the
// range. Every accepted word is predicted by a local CORDIC model and checked
// component by component against the quaternion word that comes out. Words
// are offered with random gaps and the output stalls at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int     ABITS    = e2q_pkg::ANGLE_BITS;
    localparam int     QBITS    = e2q_pkg::OUT_FRAC_BITS;
    localparam int     STAGES   = e2q_pkg::CORDIC_STAGES_DEF;
    localparam int     FRAC     = 30;
    localparam int     LATENCY  = STAGES + 4;
    localparam longint INV_GAIN = 64'sd652032874;
    localparam int     NPROBE   = 20;
    localparam int     NRANDOM  = 600;

    typedef logic signed [QBITS:0] q15_t;

    localparam q15_t Q15_MAX = {1'b0, {QBITS{1'b1}}};
    localparam q15_t Q15_MIN = {1'b1, {QBITS{1'b0}}};

    typedef enum logic [2:0] {
        TYPED_NONE,
        TYPED_X,
        TYPED_Y,
        TYPED_Z,
        TYPED_W
    } typed_field_e;

    typedef struct packed {
        e2q_pkg::angle_word_t angles;
        typed_field_e         field;
        q15_t                 value;
    } probe_row_t;

    // atan(2^-i), 2^32 phase units per turn
    longint half_atan [24] = '{
        64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4,
        64'sh028B0D43, 64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55,
        64'sh0028BE53, 64'sh00145F2F, 64'sh000A2F98, 64'sh000517CC,
        64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA, 64'sh0000517D,
        64'sh000028BE, 64'sh0000145F, 64'sh00000A30, 64'sh00000518,
        64'sh0000028C, 64'sh00000146, 64'sh000000A3, 64'sh00000051
    };

    // Half turns make one component +/-1.0; only +1.0 has to saturate.
    probe_row_t probe_rows [NPROBE] = '{
        '{'{16'h0000, 16'h0000, 16'h0000}, TYPED_W,    Q15_MAX},
        '{'{16'h8000, 16'h0000, 16'h0000}, TYPED_X,    Q15_MAX},
        '{'{16'h0000, 16'h8000, 16'h0000}, TYPED_Y,    Q15_MAX},
        '{'{16'h0000, 16'h0000, 16'h8000}, TYPED_Z,    Q15_MAX},
        '{'{16'h8000, 16'h8000, 16'h0000}, TYPED_Z,    Q15_MIN},
        '{'{16'h8000, 16'h0000, 16'h8000}, TYPED_Y,    Q15_MAX},
        '{'{16'h0000, 16'h8000, 16'h8000}, TYPED_X,    Q15_MIN},
        '{'{16'h8000, 16'h8000, 16'h8000}, TYPED_W,    Q15_MAX},
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, TYPED_NONE, '0},
        '{'{16'h7FFF, 16'h7FFF, 16'h7FFF}, TYPED_NONE, '0},
        '{'{16'h8001, 16'h8001, 16'h8001}, TYPED_NONE, '0},
        '{'{16'h0001, 16'h0001, 16'h0001}, TYPED_NONE, '0},
        '{'{16'h4000, 16'hC000, 16'h2000}, TYPED_NONE, '0},
        '{'{16'hAAAA, 16'h5555, 16'hAAAA}, TYPED_NONE, '0},
        '{'{16'h5555, 16'hAAAA, 16'h5555}, TYPED_NONE, '0},
        '{'{16'hFFFF, 16'h0000, 16'h8000}, TYPED_NONE, '0},
        '{'{16'h0001, 16'h7FFF, 16'hFFFE}, TYPED_NONE, '0},
        '{'{16'h1234, 16'h89AB, 16'hCDEF}, TYPED_NONE, '0},
        '{'{16'hC000, 16'h4000, 16'hE000}, TYPED_NONE, '0},
        '{'{16'h8000, 16'h7FFF, 16'h0001}, TYPED_NONE, '0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 angle_valid;
    logic                 angle_stall;
    e2q_pkg::angle_word_t angle;
    logic                 quat_valid;
    logic                 quat_stall;
    e2q_pkg::quat_word_t  quat;

    e2q_pkg::quat_word_t  pending_quats [$];
    int                   mismatches = 0;

    euler_to_quaternion_top #(
        .CORDIC_STAGES(STAGES)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .angle_valid(angle_valid),
        .angle_stall(angle_stall),
        .angle      (angle),
        .quat_valid (quat_valid),
        .quat_stall (quat_stall),
        .quat       (quat)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("tb failed");
        $finish;
    end

    // Q.30 product, round half up
    function automatic longint round_mul(input longint a, input longint b);
        return (a * b + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic q15_t to_q15(input longint v);
        longint r;
        r = (v + (longint'(1) <<< (FRAC - QBITS - 1))) >>> (FRAC - QBITS);
        if (r > longint'(Q15_MAX))
            r = longint'(Q15_MAX);
        if (r < longint'(Q15_MIN))
            r = longint'(Q15_MIN);
        return q15_t'(r);
    endfunction

    function automatic void half_sin_cos(
        input  logic [ABITS-1:0] ang,
        output longint           s,
        output longint           c
    );
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     upper;
        z     = longint'(ang) <<< (31 - ABITS);
        upper = (z >= (longint'(1) <<< 30));
        if (upper)
            z = z - (longint'(1) <<< 30);
        x = INV_GAIN;
        y = 0;
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - half_atan[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + half_atan[i];
            end
        end
        // fold back from the upper quadrant
        if (upper)
        begin
            s = x;
            c = -y;
        end
        else
        begin
            s = y;
            c = x;
        end
    endfunction

    function automatic e2q_pkg::quat_word_t predict_quat(input e2q_pkg::angle_word_t a);
        longint              sr, cr, sp, cp, sy, cy;
        e2q_pkg::quat_word_t q;
        half_sin_cos(a.roll_angle, sr, cr);
        half_sin_cos(a.pitch_angle, sp, cp);
        half_sin_cos(a.yaw_angle, sy, cy);
        q.quat_x = to_q15(round_mul(round_mul(sr, cp), cy) - round_mul(round_mul(cr, sp), sy));
        q.quat_y = to_q15(round_mul(round_mul(cr, sp), cy) + round_mul(round_mul(sr, cp), sy));
        q.quat_z = to_q15(round_mul(round_mul(cr, cp), sy) - round_mul(round_mul(sr, sp), cy));
        q.quat_w = to_q15(round_mul(round_mul(cr, cp), cy) + round_mul(round_mul(sr, sp), sy));
        return q;
    endfunction

    // mostly uniform, the rest around the quadrant fold and the range ends
    function automatic logic [ABITS-1:0] random_angle();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return ABITS'($urandom_range(0, (1 << ABITS) - 1));
        else if (pick < 85)
            return ABITS'((1 << (ABITS - 1)) - 16 + $urandom_range(0, 31));
        else if (pick < 93)
            return ABITS'($urandom_range(0, 15));
        else
            return ABITS'((1 << ABITS) - 16 + $urandom_range(0, 15));
    endfunction

    function automatic int sender_gap(input bit burst);
        int pick;
        pick = $urandom_range(0, 99);
        if (burst || pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic check_component(input string name, input q15_t want, input q15_t got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic send_angles(
        input e2q_pkg::angle_word_t w,
        input e2q_pkg::quat_word_t  want,
        input int                   gap
    );
        angle_valid <= 1'b1;
        angle       <= w;
        do
            @(posedge clk);
        while (angle_stall);
        pending_quats = {pending_quats, want};
        if (gap != 0)
        begin
            angle_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_quats();
        angle_valid <= 1'b0;
        while (pending_quats.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        e2q_pkg::quat_word_t want;
        if (rst_n && quat_valid && !quat_stall)
        begin
            if (pending_quats.size() == 0)
            begin
                $error("quaternion word with none expected: %h", quat);
                mismatches++;
            end
            else
            begin
                want = pending_quats.pop_front();
                check_component("quat_x", want.quat_x, quat.quat_x);
                check_component("quat_y", want.quat_y, quat.quat_y);
                check_component("quat_z", want.quat_z, quat.quat_z);
                check_component("quat_w", want.quat_w, quat.quat_w);
            end
        end
    end

    // output stall: short runs and stalls, now and then a long one of each
    initial
    begin
        quat_stall = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            quat_stall <= 1'b0;
            if ($urandom_range(0, 99) < 80)
                repeat ($urandom_range(1, 12)) @(posedge clk);
            else
                repeat ($urandom_range(50, 200)) @(posedge clk);
            quat_stall <= 1'b1;
            if ($urandom_range(0, 99) < 70)
                repeat ($urandom_range(1, 3)) @(posedge clk);
            else if ($urandom_range(0, 99) < 85)
                repeat ($urandom_range(4, 10)) @(posedge clk);
            else
                repeat ($urandom_range(20, 60)) @(posedge clk);
        end
    end

    initial
    begin
        e2q_pkg::quat_word_t  want;
        e2q_pkg::angle_word_t w;
        rst_n       = 1'b0;
        angle_valid = 1'b0;
        angle       = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NPROBE; i++)
        begin
            want = predict_quat(probe_rows[i].angles);
            case (probe_rows[i].field)
                TYPED_X: want.quat_x = probe_rows[i].value;
                TYPED_Y: want.quat_y = probe_rows[i].value;
                TYPED_Z: want.quat_z = probe_rows[i].value;
                TYPED_W: want.quat_w = probe_rows[i].value;
                default: ;
            endcase
            send_angles(probe_rows[i].angles, want, sender_gap(1'b0));
        end
        drain_quats();

        // alternate back-to-back blocks with gapped blocks
        for (int k = 0; k < NRANDOM; k++)
        begin
            if (k == NRANDOM / 2)
                drain_quats();
            w.roll_angle  = random_angle();
            w.pitch_angle = random_angle();
            w.yaw_angle   = random_angle();
            send_angles(w, predict_quat(w), sender_gap(((k / 40) % 2) == 1));
        end

        drain_quats();
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatches == 0 && pending_quats.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
